// File: rtl/trw_pkg.sv
// ----------------------------------------------------------------------------
// TLS record walk package
// Shared types and constants for the TLS record walk truncation block.
// ----------------------------------------------------------------------------
package trw_pkg;

	// Width of every length, offset and position value.
	localparam int LEN_W = 16;

	// Size of a TLS record header in bytes.
	localparam int HDR_BYTES = 5;

	// Accepted content types span this closed range.
	localparam logic [7:0] TYPE_FIRST    = 8'h14;
	localparam logic [7:0] TYPE_LAST     = 8'h17;
	localparam logic [7:0] TYPE_APP      = 8'h17;
	localparam logic [7:0] VERSION_MAJOR = 8'h03;

	// Item kinds on the input channel.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	typedef enum logic [1:0] {
		DISP_NO_RECORD  = 2'd0,
		DISP_MALFORMED  = 2'd1,
		DISP_NO_APP     = 2'd2,
		DISP_APP_PREFIX = 2'd3
	} disp_t;

	// Header byte expected next.
	typedef enum logic [2:0] {
		HDR_TYPE   = 3'd0,
		HDR_MAJOR  = 3'd1,
		HDR_MINOR  = 3'd2,
		HDR_LEN_HI = 3'd3,
		HDR_LEN_LO = 3'd4
	} hdr_idx_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        data;
		logic [LEN_W-1:0]  payload_offset;
		logic [LEN_W-1:0]  payload_length;
		logic [LEN_W-1:0]  packet_length;
	} item_t;

	typedef struct packed {
		disp_t             disposition;
		logic [LEN_W-1:0]  cut_len;
	} result_t;

	// Walk state of the packet in progress.
	typedef struct packed {
		hdr_idx_t          hdr_idx;
		logic              in_body;
		logic [LEN_W-1:0]  body_left;
		logic [LEN_W-1:0]  rec_start;
		logic [7:0]        hdr_type;
		logic [LEN_W-1:0]  hdr_len;
		logic              seen_valid;
		logic              decided;
		disp_t             held_disp;
		logic [LEN_W-1:0]  held_len;
	} walk_t;

endpackage

// File: rtl/trw_walk.sv
// ----------------------------------------------------------------------------
// TLS record walk step
// Next walk state for one payload byte: header checks, body skip and the
// application data decision.
// ----------------------------------------------------------------------------
module trw_walk (
	input  trw_pkg::walk_t                 cur,
	input  logic [7:0]                     byte_in,
	input  logic [trw_pkg::LEN_W-1:0]      pos_next,
	input  logic [trw_pkg::LEN_W-1:0]      keep,
	input  logic [trw_pkg::LEN_W-1:0]      pl_off,
	input  logic [trw_pkg::LEN_W-1:0]      pl_pkt,
	output trw_pkg::walk_t                 nxt
);

	logic                          rec_done;
	logic                          bad_hdr;
	logic [trw_pkg::LEN_W-1:0]     body_dec;
	logic [trw_pkg::LEN_W-1:0]     body_len;
	logic [trw_pkg::LEN_W-1:0]     kept;
	logic [trw_pkg::LEN_W-1:0]     app_len;

	assign body_dec = cur.body_left - trw_pkg::LEN_W'(1);
	assign body_len = {cur.hdr_len[trw_pkg::LEN_W-1:8], byte_in};

	always_comb begin
		nxt      = cur;
		rec_done = 1'b0;
		bad_hdr  = 1'b0;
		kept     = '0;
		app_len  = '0;

		if (cur.in_body) begin
			nxt.body_left = body_dec;
			if (body_dec == '0) begin
				nxt.in_body = 1'b0;
				rec_done    = 1'b1;
			end
		end else begin
			unique case (cur.hdr_idx)
				trw_pkg::HDR_TYPE: begin
					if (byte_in < trw_pkg::TYPE_FIRST || byte_in > trw_pkg::TYPE_LAST) begin
						bad_hdr = 1'b1;
					end else begin
						nxt.hdr_type = byte_in;
						nxt.hdr_idx  = trw_pkg::HDR_MAJOR;
					end
				end
				trw_pkg::HDR_MAJOR: begin
					if (byte_in != trw_pkg::VERSION_MAJOR) begin
						bad_hdr = 1'b1;
					end else begin
						nxt.hdr_idx = trw_pkg::HDR_MINOR;
					end
				end
				trw_pkg::HDR_MINOR: begin
					nxt.hdr_idx = trw_pkg::HDR_LEN_HI;
				end
				trw_pkg::HDR_LEN_HI: begin
					nxt.hdr_len[trw_pkg::LEN_W-1:8] = byte_in;
					nxt.hdr_idx = trw_pkg::HDR_LEN_LO;
				end
				default: begin
					nxt.hdr_len    = body_len;
					nxt.hdr_idx    = trw_pkg::HDR_TYPE;
					nxt.seen_valid = 1'b1;
					nxt.body_left  = body_len;
					if (body_len == '0) begin
						rec_done = 1'b1;
					end else begin
						nxt.in_body = 1'b1;
					end
				end
			endcase
		end

		if (bad_hdr) begin
			nxt.decided   = 1'b1;
			nxt.held_disp = cur.seen_valid ? trw_pkg::DISP_MALFORMED : trw_pkg::DISP_NO_RECORD;
			nxt.held_len  = pl_pkt;
		end

		// A finished application data record ends the walk; any other record
		// moves the record start past it.
		if (rec_done) begin
			if (nxt.hdr_type == trw_pkg::TYPE_APP) begin
				kept          = (nxt.hdr_len < keep) ? nxt.hdr_len : keep;
				app_len       = pl_off + cur.rec_start + trw_pkg::LEN_W'(trw_pkg::HDR_BYTES) + kept;
				nxt.decided   = 1'b1;
				nxt.held_disp = trw_pkg::DISP_APP_PREFIX;
				nxt.held_len  = app_len;
			end else begin
				nxt.rec_start = pos_next;
			end
		end
	end

endmodule

// File: rtl/tls_record_walk_truncation.sv
// ----------------------------------------------------------------------------
// TLS record walk truncation
// Walks the TLS records of one TCP payload and decides how many bytes of the
// captured packet to keep.
// ----------------------------------------------------------------------------
//
// Channel  Handshake              Payload              Direction
// -------  ---------------------  -------------------  ---------
// item     item_valid/item_stall  trw_pkg::item_t      in
// result   result_valid/stall     trw_pkg::result_t    out
// cfg      cfg_valid/cfg_ready    keep_app_bytes (16)  in
//
// Every item is handled in the cycle it is accepted, so one item per cycle is
// taken while the result side keeps up; each result is registered in the
// output register, or in the skid entry while the output register is held.
// The result register is backed by one skid entry, so an item is still taken
// while a result waits; item_stall rises only once both hold a result.
// Reset clears the walk state, the packet lengths and keep_app_bytes to zero.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module tls_record_walk_truncation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  trw_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output trw_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [trw_pkg::LEN_W-1:0]     cfg_data
);

	// Configuration register and per-packet lengths.
	logic [trw_pkg::LEN_W-1:0] keep_q;
	logic [trw_pkg::LEN_W-1:0] off_q, off_d;
	logic [trw_pkg::LEN_W-1:0] len_q, len_d;
	logic [trw_pkg::LEN_W-1:0] pkt_q, pkt_d;
	logic [trw_pkg::LEN_W-1:0] pos_q, pos_d;
	logic [trw_pkg::LEN_W-1:0] pos_inc;
	trw_pkg::walk_t            walk_q, walk_d, walk_nx;

	// Result produced by the item in this cycle.
	logic                      res_valid;
	trw_pkg::result_t          res;
	logic [trw_pkg::LEN_W:0]   range_end;

	// Output register and its skid entry.
	logic                      out_valid_q;
	trw_pkg::result_t          out_q;
	logic                      skid_valid_q;
	trw_pkg::result_t          skid_q;

	logic                      item_xfer;
	logic                      out_free;

	assign cfg_ready    = 1'b1;
	assign item_stall   = skid_valid_q;
	assign item_xfer    = item_valid && !skid_valid_q;
	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign pos_inc   = pos_q + trw_pkg::LEN_W'(1);
	assign range_end = {1'b0, item.payload_offset} + {1'b0, item.payload_length};

	trw_walk u_walk (
		.cur      (walk_q),
		.byte_in  (item.data),
		.pos_next (pos_inc),
		.keep     (keep_q),
		.pl_off   (off_q),
		.pl_pkt   (pkt_q),
		.nxt      (walk_nx)
	);

	always_comb begin
		walk_d    = walk_q;
		pos_d     = pos_q;
		off_d     = off_q;
		len_d     = len_q;
		pkt_d     = pkt_q;
		res_valid = 1'b0;
		res       = '0;

		if (item_xfer) begin
			if (item.kind == trw_pkg::KIND_START) begin
				// A start drops any packet in progress and restarts the walk.
				walk_d = '0;
				pos_d  = '0;
				pkt_d  = item.packet_length;
				if (range_end > {1'b0, item.packet_length}) begin
					// Payload range reaches past the packet: answer at once
					// and ignore any bytes that still come.
					off_d          = '0;
					len_d          = '0;
					res_valid      = 1'b1;
					res.disposition = trw_pkg::DISP_MALFORMED;
					res.cut_len    = item.packet_length;
				end else if (item.payload_length == '0) begin
					off_d          = '0;
					len_d          = '0;
					res_valid      = 1'b1;
					res.disposition = trw_pkg::DISP_NO_APP;
					res.cut_len    = item.packet_length;
				end else begin
					off_d = item.payload_offset;
					len_d = item.payload_length;
				end
			end else if (pos_q < len_q) begin
				// Bytes past the payload or with no packet open are dropped.
				pos_d = pos_inc;
				if (!walk_q.decided) begin
					walk_d = walk_nx;
				end
				if (pos_inc == len_q) begin
					res_valid = 1'b1;
					if (walk_d.decided) begin
						res.disposition = walk_d.held_disp;
						res.cut_len     = walk_d.held_len;
					end else if (walk_d.hdr_idx == trw_pkg::HDR_TYPE && !walk_d.in_body) begin
						// Payload ended exactly on a record boundary.
						res.disposition = trw_pkg::DISP_NO_APP;
						res.cut_len     = pkt_q;
					end else begin
						// Payload ended inside a header or a body.
						res.disposition = trw_pkg::DISP_MALFORMED;
						res.cut_len     = pkt_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= '0;
			walk_q <= '0;
			pos_q  <= '0;
			off_q  <= '0;
			len_q  <= '0;
			pkt_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				keep_q <= cfg_data;
			end
			walk_q <= walk_d;
			pos_q  <= pos_d;
			off_q  <= off_d;
			len_q  <= len_d;
			pkt_q  <= pkt_d;
		end
	end

	// The skid entry fills only while the output register is held; while it
	// is full no item is taken, so it drains into the output register first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

endmodule
